FILE: hdl/mbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// mbq_pkg: types, constants and microcode ROM of the multichannel biquad core.
// Used by mbq_useq, mbq_datapath and multichannel_biquad_lowpass_core.
package mbq_pkg;

  localparam int NumCoefs       = 5;
  localparam int CfgIdxW        = 3;
  localparam int CoefW          = 32;
  localparam int SampleW        = 32;
  localparam int ChanW          = 3;
  localparam int DelayW         = 40;
  localparam int SampleFracBits = 16;
  localparam int CoefFracBits   = 30;
  localparam int PartW          = 21;
  localparam int MulW           = CoefW + PartW;
  localparam int ProdW          = 72;
  localparam int SumW           = 48;
  localparam int StepW          = 5;

  localparam logic signed [DelayW-1:0] DelayReset = 40'sd256 <<< SampleFracBits;
  localparam logic signed [ProdW-1:0]  ProdBias   = 72'sd1 <<< (CoefFracBits - 1);

  typedef enum logic [2:0] {
    IDX_B0 = 3'd0,
    IDX_B1 = 3'd1,
    IDX_B2 = 3'd2,
    IDX_A1 = 3'd3,
    IDX_A2 = 3'd4
  } coef_idx_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_INPUT,
    HOLD_OUT_BUSY
  } hold_e;

  typedef enum logic [1:0] {
    JUMP_NEVER,
    JUMP_ALWAYS,
    JUMP_BAD_CH
  } jump_e;

  typedef enum logic [1:0] {
    OPD_D1,
    OPD_D2,
    OPD_W
  } opd_e;

  typedef enum logic {
    HALF_LO,
    HALF_HI
  } half_e;

  typedef enum logic [1:0] {
    PROD_KEEP,
    PROD_LOAD_LO,
    PROD_ADD_HI
  } prod_e;

  typedef enum logic [1:0] {
    SUM_KEEP,
    SUM_CLEAR,
    SUM_LOAD_X,
    SUM_ADD_TERM
  } sum_e;

  typedef struct packed {
    hold_e            hold;
    jump_e            jump;
    logic [StepW-1:0] target;
    logic             load_d;
    logic             mul_en;
    coef_idx_e        coef_sel;
    opd_e             opd_sel;
    half_e            half;
    prod_e            prod_op;
    sum_e             sum_op;
    logic             w_en;
    logic             state_we;
    logic             out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic bad_ch;
  } status_t;

  localparam logic [StepW-1:0] StepIdle = 5'd0;
  localparam logic [StepW-1:0] StepOut  = 5'd17;

  localparam ctrl_t CtrlNop = '{
    hold:     HOLD_NONE,
    jump:     JUMP_NEVER,
    target:   StepIdle,
    load_d:   1'b0,
    mul_en:   1'b0,
    coef_sel: IDX_B0,
    opd_sel:  OPD_D1,
    half:     HALF_LO,
    prod_op:  PROD_KEEP,
    sum_op:   SUM_KEEP,
    w_en:     1'b0,
    state_we: 1'b0,
    out_load: 1'b0
  };

  // Ten partial products through one 32x21 multiplier, feedback first.
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t c;
    c = CtrlNop;
    unique case (step)
      5'd0: begin
        c.hold = HOLD_NO_INPUT;
      end
      5'd1: begin
        c.load_d = 1'b1;
        c.sum_op = SUM_CLEAR;
        c.jump   = JUMP_BAD_CH;
        c.target = StepOut;
      end
      5'd2: begin
        c.mul_en = 1'b1; c.coef_sel = IDX_A1; c.opd_sel = OPD_D1; c.half = HALF_LO;
        c.sum_op = SUM_LOAD_X;
      end
      5'd3: begin
        c.mul_en = 1'b1; c.coef_sel = IDX_A1; c.opd_sel = OPD_D1; c.half = HALF_HI;
        c.prod_op = PROD_LOAD_LO;
      end
      5'd4: begin
        c.mul_en = 1'b1; c.coef_sel = IDX_A2; c.opd_sel = OPD_D2; c.half = HALF_LO;
        c.prod_op = PROD_ADD_HI;
      end
      5'd5: begin
        c.mul_en = 1'b1; c.coef_sel = IDX_A2; c.opd_sel = OPD_D2; c.half = HALF_HI;
        c.prod_op = PROD_LOAD_LO;
        c.sum_op  = SUM_ADD_TERM;
      end
      5'd6: begin
        c.prod_op = PROD_ADD_HI;
      end
      5'd7: begin
        c.sum_op = SUM_ADD_TERM;
      end
      5'd8: begin
        c.w_en   = 1'b1;
        c.sum_op = SUM_CLEAR;
      end
      5'd9: begin
        c.mul_en = 1'b1; c.coef_sel = IDX_B0; c.opd_sel = OPD_W; c.half = HALF_LO;
        c.state_we = 1'b1;
      end
      5'd10: begin
        c.mul_en = 1'b1; c.coef_sel = IDX_B0; c.opd_sel = OPD_W; c.half = HALF_HI;
        c.prod_op = PROD_LOAD_LO;
      end
      5'd11: begin
        c.mul_en = 1'b1; c.coef_sel = IDX_B1; c.opd_sel = OPD_D1; c.half = HALF_LO;
        c.prod_op = PROD_ADD_HI;
      end
      5'd12: begin
        c.mul_en = 1'b1; c.coef_sel = IDX_B1; c.opd_sel = OPD_D1; c.half = HALF_HI;
        c.prod_op = PROD_LOAD_LO;
        c.sum_op  = SUM_ADD_TERM;
      end
      5'd13: begin
        c.mul_en = 1'b1; c.coef_sel = IDX_B2; c.opd_sel = OPD_D2; c.half = HALF_LO;
        c.prod_op = PROD_ADD_HI;
      end
      5'd14: begin
        c.mul_en = 1'b1; c.coef_sel = IDX_B2; c.opd_sel = OPD_D2; c.half = HALF_HI;
        c.prod_op = PROD_LOAD_LO;
        c.sum_op  = SUM_ADD_TERM;
      end
      5'd15: begin
        c.prod_op = PROD_ADD_HI;
      end
      5'd16: begin
        c.sum_op = SUM_ADD_TERM;
      end
      5'd17: begin
        c.hold     = HOLD_OUT_BUSY;
        c.jump     = JUMP_ALWAYS;
        c.target   = StepIdle;
        c.out_load = 1'b1;
      end
      default: begin
        c.jump   = JUMP_ALWAYS;
        c.target = StepIdle;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/mbq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// mbq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mbq_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mbq_useq.sv
`timescale 1ns / 1ps
`default_nettype none
// mbq_useq: step counter and microcode ROM lookup with hold and jump conditions.
// Depends on mbq_pkg.
module mbq_useq
  import mbq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  output ctrl_t        ctrl_o
);

  logic [StepW-1:0] step_q, step_d;
  logic             hold;
  logic             jump;

  assign ctrl_o = ucode(step_q);

  always_comb begin
    unique case (ctrl_o.hold)
      HOLD_NONE:     hold = 1'b0;
      HOLD_NO_INPUT: hold = !status_i.in_valid;
      HOLD_OUT_BUSY: hold = status_i.out_busy;
      default:       hold = 1'b0;
    endcase
    unique case (ctrl_o.jump)
      JUMP_NEVER:  jump = 1'b0;
      JUMP_ALWAYS: jump = 1'b1;
      JUMP_BAD_CH: jump = status_i.bad_ch;
      default:     jump = 1'b0;
    endcase
    priority if (hold) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = ctrl_o.target;
    end else begin
      step_d = step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mbq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// mbq_datapath: delay state RAM, shared multiplier, product and sum accumulators,
// saturation and output register. Depends on mbq_pkg and mbq_ram.
module mbq_datapath
  import mbq_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ctrl_t                     ctrl_i,
  input  wire logic signed [CoefW-1:0]   coef_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic        [ChanW-1:0]   channel_i,
  input  wire logic signed [SampleW-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic             [ChanW-1:0]   result_channel_o,
  output logic signed      [SampleW-1:0] filtered_o,
  output status_t                        status_o
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                       accept;
  logic                       bad_ch;
  logic                       out_busy;
  logic                       out_load;
  logic [ChanW-1:0]           ch_q;
  logic signed [SampleW-1:0]  x_q;
  logic signed [DelayW-1:0]   d1_q, d2_q, w_q;
  logic signed [DelayW-1:0]   opd;
  logic signed [PartW-1:0]    part;
  logic signed [MulW-1:0]     mul_q;
  logic signed [ProdW-1:0]    prod_q;
  logic signed [SumW-1:0]     sum_q;
  logic signed [SumW-1:0]     term;
  logic signed [DelayW-1:0]   w_sat;
  logic signed [SampleW-1:0]  y_sat;
  logic [CHANNELS-1:0]        valid_q;
  logic                       rd_valid_q;
  logic [2*DelayW-1:0]        rdata;
  logic [AW-1:0]              raddr;
  logic [AW-1:0]              waddr;
  logic                       out_valid_q;
  logic [ChanW-1:0]           res_ch_q;
  logic signed [SampleW-1:0]  filtered_q;

  assign accept     = (ctrl_i.hold == HOLD_NO_INPUT) && in_valid_i;
  assign in_stall_o = (ctrl_i.hold != HOLD_NO_INPUT);
  assign bad_ch     = (32'(ch_q) >= 32'(CHANNELS));
  assign out_busy   = out_valid_q && out_stall_i;
  assign out_load   = ctrl_i.out_load && !out_busy;
  assign raddr      = AW'(channel_i);
  assign waddr      = AW'(ch_q);

  assign status_o = '{in_valid: in_valid_i, out_busy: out_busy, bad_ch: bad_ch};

  mbq_ram #(
    .WIDTH (2 * DelayW),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.state_we),
    .waddr_i (waddr),
    .wdata_i ({w_q, d1_q}),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Unwritten channels read as the reset delay value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.state_we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (accept) begin
        rd_valid_q <= valid_q[raddr];
      end
    end
  end

  always_comb begin
    unique case (ctrl_i.opd_sel)
      OPD_D1:  opd = d1_q;
      OPD_D2:  opd = d2_q;
      OPD_W:   opd = w_q;
      default: opd = d1_q;
    endcase
    unique case (ctrl_i.half)
      HALF_LO: part = {1'b0, opd[19:0]};
      HALF_HI: part = {opd[DelayW-1], opd[DelayW-1:20]};
      default: part = {1'b0, opd[19:0]};
    endcase
  end

  assign term = {{(SumW - (ProdW - CoefFracBits)){prod_q[ProdW-1]}},
                 prod_q[ProdW-1:CoefFracBits]};

  always_comb begin
    if ((&sum_q[SumW-1:DelayW-1]) || !(|sum_q[SumW-1:DelayW-1])) begin
      w_sat = sum_q[DelayW-1:0];
    end else begin
      w_sat = sum_q[SumW-1] ? {1'b1, {(DelayW-1){1'b0}}} : {1'b0, {(DelayW-1){1'b1}}};
    end
    if ((&sum_q[SumW-1:SampleW-1]) || !(|sum_q[SumW-1:SampleW-1])) begin
      y_sat = sum_q[SampleW-1:0];
    end else begin
      y_sat = sum_q[SumW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q <= channel_i;
      x_q  <= sample_in_i;
    end
    if (ctrl_i.load_d) begin
      d1_q <= rd_valid_q ? rdata[2*DelayW-1:DelayW] : DelayReset;
      d2_q <= rd_valid_q ? rdata[DelayW-1:0] : DelayReset;
    end
    if (ctrl_i.mul_en) begin
      mul_q <= MulW'(coef_i) * MulW'(part);
    end
    unique case (ctrl_i.prod_op)
      PROD_KEEP:    prod_q <= prod_q;
      PROD_LOAD_LO: prod_q <= {{(ProdW - MulW){mul_q[MulW-1]}}, mul_q} + ProdBias;
      PROD_ADD_HI:  prod_q <= prod_q + {mul_q[ProdW-21:0], 20'b0};
      default:      prod_q <= prod_q;
    endcase
    unique case (ctrl_i.sum_op)
      SUM_KEEP:     sum_q <= sum_q;
      SUM_CLEAR:    sum_q <= '0;
      SUM_LOAD_X:   sum_q <= {{(SumW - SampleW){x_q[SampleW-1]}}, x_q};
      SUM_ADD_TERM: sum_q <= sum_q + term;
      default:      sum_q <= sum_q;
    endcase
    if (ctrl_i.w_en) begin
      w_q <= w_sat;
    end
    if (out_load) begin
      res_ch_q   <= ch_q;
      filtered_q <= y_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_channel_o = res_ch_q;
  assign filtered_o       = filtered_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input taken again right after a transfer");

  a_write_valid_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.state_we |-> !bad_ch)
    else $error("delay write for a channel out of range");

  a_write_after_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.state_we |-> $past(ctrl_i.w_en))
    else $error("delay write without a fresh w");

  a_bad_ch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (32'(result_channel_o) >= 32'(CHANNELS))) |-> (filtered_o == '0))
    else $error("nonzero result for a channel out of range");

endmodule
`default_nettype wire

FILE: hdl/multichannel_biquad_lowpass_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Multichannel biquad low-pass core, direct form II, per-channel delay state.
// Input channel: in_valid_i / in_stall_o with channel_i and sample_in_i (Q16.16).
// Output channel: out_valid_o / out_stall_i with result_channel_o and filtered_o.
// Coefficient port: cfg_valid_i / cfg_ready_o, cfg_index_i selects b0, b1, b2, a1, a2
// (Q2.30, a1 and a2 stored negated); write only while no sample is in flight.
// A microcoded sequencer drives one 32x21 multiplier that forms ten partial
// products per sample; the input is taken in the idle step and the result
// register loads in the output step. A channel at or above CHANNELS skips the
// multiply steps and returns zero without touching state.
// Reset loads the default coefficients and marks every channel's delays as
// 256.0; there is no clearing pass. A result waits in the output register while
// the receiver stalls; the next sample is still taken and runs until its own
// result is ready, then holds there until the register frees.
// Depends on mbq_pkg, mbq_useq, mbq_datapath and mbq_ram.
module multichannel_biquad_lowpass_core
  import mbq_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic        [ChanW-1:0]   channel_i,
  input  wire logic signed [SampleW-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic             [ChanW-1:0]   result_channel_o,
  output logic signed      [SampleW-1:0] filtered_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic        [CfgIdxW-1:0] cfg_index_i,
  input  wire logic        [CoefW-1:0]   cfg_data_i
);

  ctrl_t                    ctrl;
  status_t                  status;
  logic signed [CoefW-1:0]  coef_q [NumCoefs];
  logic signed [CoefW-1:0]  coef_sel;

  assign cfg_ready_o = 1'b1;
  assign coef_sel    = coef_q[ctrl.coef_sel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[IDX_B0] <= 32'sd5494000;
      coef_q[IDX_B1] <= 32'sd10988000;
      coef_q[IDX_B2] <= 32'sd5494000;
      coef_q[IDX_A1] <= 32'sd1733868000;
      coef_q[IDX_A2] <= -32'sd682107000;
    end else if (cfg_valid_i && cfg_ready_o && (32'(cfg_index_i) < NumCoefs)) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  mbq_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  mbq_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .coef_i           (coef_sel),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .channel_i        (channel_i),
    .sample_in_i      (sample_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_channel_o (result_channel_o),
    .filtered_o       (filtered_o),
    .status_o         (status)
  );

endmodule
`default_nettype wire
